// ----- rtl/pmtps_pkg.sv -----
// Shared types, constants and the tap coefficient function for the PMT pulse shaper.
// Depends on nothing; used by every module under rtl/.
package pmtps_pkg;

    localparam int TAPS     = 40;    // 8..128
    localparam int AMP_W    = 16;    // input amplitude, Q8.8
    localparam int COEF_W   = 15;    // tap, unsigned Q1.14 (peak about 1.02)
    localparam int ACC_W    = 40;    // partial sums, generous headroom
    localparam int FRAC_SH  = 14;
    localparam int SUM_W    = ACC_W - FRAC_SH;
    localparam int SAMPLE_W = 24;
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = 3;

    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = {SAMPLE_W{1'b1}};

    // register index, taken from paddr[ADDR_W-1:2]
    localparam logic REG_THRESHOLD = 1'b0;

    // exp(-1/3.5) in Q0.30 and the rounding terms of the tap formula
    localparam logic [63:0] EXP_STEP_Q30 = 64'd806892599;
    localparam logic [63:0] ONE_Q30      = 64'd1073741824;
    localparam logic [63:0] TAP_RND      = 64'd40960;   // 5 * 2^13
    localparam logic [63:0] TAP_DIV      = 64'd81920;   // 5 * 2^14

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                above;
        logic                rise;
        logic                fall;
    } disc_res_t;

    // h[k] = round(0.8*k*exp(-k/3.5) * 2^14), evaluated at elaboration
    function automatic logic [COEF_W-1:0] tap_coef(input int unsigned k);
        logic [63:0] e;
        logic [63:0] num;
        e = ONE_Q30;
        for (int unsigned i = 0; i < k; i++) begin
            e = (e * EXP_STEP_Q30 + (ONE_Q30 >> 1)) >> 30;
        end
        num = 64'(k) * e + TAP_RND;
        return COEF_W'(num / TAP_DIV);
    endfunction

endpackage

// ----- rtl/pmtps_cell.sv -----
// One cell of the transposed FIR chain: multiply the broadcast amplitude by
// this cell's tap and add the neighbor's partial sum. Depends on pmtps_pkg.
module pmtps_cell (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic [pmtps_pkg::AMP_W-1:0] x,
    input  logic [pmtps_pkg::COEF_W-1:0] coef,
    input  logic [pmtps_pkg::ACC_W-1:0] sum_in,
    output logic [pmtps_pkg::ACC_W-1:0] sum_out
);

    logic [pmtps_pkg::ACC_W-1:0] sum_reg;
    logic [pmtps_pkg::ACC_W-1:0] sum_next;
    logic [pmtps_pkg::AMP_W+pmtps_pkg::COEF_W-1:0] prod;

    assign prod     = x * coef;
    assign sum_next = sum_in + pmtps_pkg::ACC_W'(prod);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
        end else if (en) begin
            sum_reg <= sum_next;
        end
    end

    assign sum_out = sum_reg;

endmodule

// ----- rtl/pmtps_chain.sv -----
// Row of TAPS-1 FIR cells; tap 0 is zero so the head cell's sum is the output.
// Depends on pmtps_pkg and pmtps_cell.
module pmtps_chain (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic [pmtps_pkg::AMP_W-1:0] x,
    output logic [pmtps_pkg::ACC_W-1:0] acc
);

    logic [pmtps_pkg::ACC_W-1:0] sum_w [1:pmtps_pkg::TAPS];

    assign sum_w[pmtps_pkg::TAPS] = '0;

    for (genvar k = 1; k < pmtps_pkg::TAPS; k++) begin : g_cell
        pmtps_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .x       (x),
            .coef    (pmtps_pkg::tap_coef(k)),
            .sum_in  (sum_w[k+1]),
            .sum_out (sum_w[k])
        );
    end

    assign acc = sum_w[1];

endmodule

// ----- rtl/pmtps_disc.sv -----
// Scaling, saturation and leading-edge discriminator with its above flag.
// Depends on pmtps_pkg.
module pmtps_disc (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           en,
    input  logic [pmtps_pkg::ACC_W-1:0]    acc,
    input  logic [pmtps_pkg::SAMPLE_W-1:0] threshold,
    output pmtps_pkg::disc_res_t           res
);

    logic                           above_reg;
    logic [pmtps_pkg::SUM_W-1:0]    shifted;
    logic [pmtps_pkg::SAMPLE_W-1:0] sat;

    assign shifted = acc[pmtps_pkg::ACC_W-1:pmtps_pkg::FRAC_SH];
    assign sat = (shifted > pmtps_pkg::SUM_W'(pmtps_pkg::SAMPLE_MAX))
               ? pmtps_pkg::SAMPLE_MAX : shifted[pmtps_pkg::SAMPLE_W-1:0];

    always_comb begin
        res.sample = sat;
        res.rise   = 1'b0;
        res.fall   = 1'b0;
        res.above  = above_reg;
        // equal to threshold keeps the current state
        if (!above_reg && sat > threshold) begin
            res.rise  = 1'b1;
            res.above = 1'b1;
        end else if (above_reg && sat < threshold) begin
            res.fall  = 1'b1;
            res.above = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            above_reg <= 1'b0;
        end else if (en) begin
            above_reg <= res.above;
        end
    end

endmodule

// ----- rtl/pmt_pulse_shaper_discriminator.sv -----
// PMT pulse shaper and leading-edge discriminator. Each transfer on s_ carries the
// photoelectron amplitude of one 0.1 ns tick; each produces one m_ transfer with the
// shaped sample (40-tap FIR, >>14, saturated to 24 bits) and the above/rise/fall flags.
// Throughput is one item per cycle: the FIR is a chain of one multiply-add cell per
// nonzero tap that advances on every accepted transfer, and m_valid is set in the cycle
// after it. A result held by a low m_ready stalls s_ready; a new item gets in on the
// cycle the held result is taken, so a steady m_ready keeps the pipe full. Threshold
// is written through the APB port at address 0; the user does so only while the block
// is idle (not enforced). Depends on pmtps_pkg, pmtps_chain, pmtps_cell and pmtps_disc.
module pmt_pulse_shaper_discriminator (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pmtps_pkg::ADDR_W-1:0]    paddr,
    input  logic [pmtps_pkg::DATA_W-1:0]    pwdata,
    output logic [pmtps_pkg::DATA_W-1:0]    prdata,
    output logic                            pready,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [pmtps_pkg::AMP_W-1:0]     s_pe_amplitude,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [pmtps_pkg::SAMPLE_W-1:0]  m_sample,
    output logic                            m_above,
    output logic                            m_rise,
    output logic                            m_fall
);

    logic [pmtps_pkg::SAMPLE_W-1:0] threshold_reg;
    logic                           reg_idx;
    logic                           cfg_wr;
    logic                           s_xfer;
    logic [pmtps_pkg::ACC_W-1:0]    acc;
    pmtps_pkg::disc_res_t           res;
    pmtps_pkg::disc_res_t           out_reg;
    logic                           m_valid_reg;

    // configuration port
    assign pready  = 1'b1;
    assign reg_idx = paddr[pmtps_pkg::ADDR_W-1];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= '0;
        end else if (cfg_wr && reg_idx == pmtps_pkg::REG_THRESHOLD) begin
            threshold_reg <= pwdata[pmtps_pkg::SAMPLE_W-1:0];
        end
    end

    always_comb begin
        unique case (reg_idx)
            pmtps_pkg::REG_THRESHOLD:
                prdata = pmtps_pkg::DATA_W'(threshold_reg);
            default: prdata = '0;
        endcase
    end

    // datapath
    assign s_ready = !m_valid_reg || m_ready;
    assign s_xfer  = s_valid && s_ready;

    pmtps_chain u_chain (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (s_xfer),
        .x       (s_pe_amplitude),
        .acc     (acc)
    );

    pmtps_disc u_disc (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (s_xfer),
        .acc       (acc),
        .threshold (threshold_reg),
        .res       (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_xfer) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            out_reg <= res;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_sample = out_reg.sample;
    assign m_above  = out_reg.above;
    assign m_rise   = out_reg.rise;
    assign m_fall   = out_reg.fall;

    a_rise_fall_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(out_reg.rise && out_reg.fall))
        else $error("rise and fall both set");

    a_rise_above: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && out_reg.rise) |-> out_reg.above)
        else $error("rise without above");

    a_fall_below: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && out_reg.fall) |-> !out_reg.above)
        else $error("fall while above");

    a_xfer_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer |=> m_valid_reg)
        else $error("accepted item produced no result");

endmodule

// ----- test/tb_pmt_pulse_shaper_discriminator.sv -----
// Testbench for pmt_pulse_shaper_discriminator: directed table, then random pulse trains.
// Predicts every sample and discriminator flag, and checks each m_ transfer in order.
// Depends on rtl/pmtps_pkg.sv and rtl/pmt_pulse_shaper_discriminator.sv.
`timescale 1ns / 100ps

module tb_pmt_pulse_shaper_discriminator;

    localparam int          RANDOM_ITEMS  = 1530;
    localparam int          HOLD_AT       = 400;
    localparam int          HOLD_CYCLES   = 80;
    localparam int          CALM_FIRST    = 700;
    localparam int          CALM_LAST     = 1000;
    localparam int          SETTLE_CYCLES = 4;
    localparam int          DRAIN_CYCLES  = 10;
    localparam int unsigned CYCLE_LIMIT   = 200000;
    localparam int          PLAN_ROWS     = 19;

    localparam logic [pmtps_pkg::ADDR_W-1:0] ADDR_THRESHOLD =
        {pmtps_pkg::REG_THRESHOLD, 2'b00};
    localparam logic [pmtps_pkg::ADDR_W-1:0] ADDR_UNUSED    =
        {~pmtps_pkg::REG_THRESHOLD, 2'b00};

    // pulse shape: decay per tick exp(-1/3.5) in Q0.30, tap = k*e[k]/(5*2^14) rounded
    localparam logic [63:0] DECAY_Q30 = 64'd806892599;
    localparam logic [63:0] UNIT_Q30  = 64'd1 << 30;
    localparam logic [63:0] SHAPE_RND = 64'd40960;
    localparam logic [63:0] SHAPE_DIV = 64'd81920;

    localparam int MODE_SPARSE  = 0;
    localparam int MODE_DENSE   = 1;
    localparam int MODE_BURST   = 2;
    localparam int MODE_ANY     = 3;

    typedef struct packed {
        logic                            wr;
        logic [pmtps_pkg::ADDR_W-1:0]    waddr;
        logic [pmtps_pkg::DATA_W-1:0]    wdata;
        logic [pmtps_pkg::AMP_W-1:0]     amp;
        logic                            typed;
        pmtps_pkg::disc_res_t            res;
    } plan_row_t;

    logic                                aclk;
    logic                                aresetn;
    logic                                psel;
    logic                                penable;
    logic                                pwrite;
    logic [pmtps_pkg::ADDR_W-1:0]        paddr;
    logic [pmtps_pkg::DATA_W-1:0]        pwdata;
    logic [pmtps_pkg::DATA_W-1:0]        prdata;
    logic                                pready;
    logic                                s_valid;
    logic                                s_ready;
    logic [pmtps_pkg::AMP_W-1:0]         s_pe_amplitude;
    logic                                m_valid;
    logic                                m_ready;
    logic [pmtps_pkg::SAMPLE_W-1:0]      m_sample;
    logic                                m_above;
    logic                                m_rise;
    logic                                m_fall;

    // shaper model state
    logic [63:0]                         shape_tap [pmtps_pkg::TAPS];
    logic [pmtps_pkg::AMP_W-1:0]         amp_line [pmtps_pkg::TAPS-1];
    logic                                disc_above;
    logic [pmtps_pkg::SAMPLE_W-1:0]      thr_cfg;

    pmtps_pkg::disc_res_t                expected_samples [$];
    pmtps_pkg::disc_res_t                typed_res;
    logic                                typed_valid;
    plan_row_t                           plan [PLAN_ROWS];
    int unsigned                         mismatches;
    int unsigned                         cycles;
    bit                                  calm;
    bit                                  hold_req;

    pmt_pulse_shaper_discriminator uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_pe_amplitude (s_pe_amplitude),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_sample       (m_sample),
        .m_above        (m_above),
        .m_rise         (m_rise),
        .m_fall         (m_fall)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic void log_mismatch(string what, pmtps_pkg::disc_res_t want,
                                         pmtps_pkg::disc_res_t got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("mismatch (%s): expected sample %h above %b rise %b fall %b,",
                     what, want.sample, want.above, want.rise, want.fall);
            $display("    got sample %h above %b rise %b fall %b",
                     got.sample, got.above, got.rise, got.fall);
        end
    endfunction

    // one tick of the FIR and the leading-edge discriminator
    function automatic pmtps_pkg::disc_res_t shape_and_discriminate(
        input logic [pmtps_pkg::AMP_W-1:0] amp);
        logic [63:0]          acc;
        logic [63:0]          s;
        pmtps_pkg::disc_res_t r;
        acc = shape_tap[0] * 64'(amp);
        for (int k = 1; k < pmtps_pkg::TAPS; k++) begin
            acc += shape_tap[k] * 64'(amp_line[k-1]);
        end
        for (int k = pmtps_pkg::TAPS - 2; k > 0; k--) begin
            amp_line[k] = amp_line[k-1];
        end
        amp_line[0] = amp;
        s = acc >> pmtps_pkg::FRAC_SH;
        if (s > 64'(pmtps_pkg::SAMPLE_MAX)) begin
            s = 64'(pmtps_pkg::SAMPLE_MAX);
        end
        r.rise = 1'b0;
        r.fall = 1'b0;
        if (!disc_above && s > 64'(thr_cfg)) begin
            disc_above = 1'b1;
            r.rise     = 1'b1;
        end else if (disc_above && s < 64'(thr_cfg)) begin
            disc_above = 1'b0;
            r.fall     = 1'b1;
        end
        r.sample = s[pmtps_pkg::SAMPLE_W-1:0];
        r.above  = disc_above;
        return r;
    endfunction

    // transfer tracking on both channels
    always @(posedge aclk) begin
        pmtps_pkg::disc_res_t pred;
        pmtps_pkg::disc_res_t entry;
        pmtps_pkg::disc_res_t got;
        pmtps_pkg::disc_res_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                pred             = shape_and_discriminate(s_pe_amplitude);
                entry            = typed_valid ? typed_res : pred;
                expected_samples = {expected_samples, entry};
            end
            if (m_valid && m_ready) begin
                got.sample = m_sample;
                got.above  = m_above;
                got.rise   = m_rise;
                got.fall   = m_fall;
                if (expected_samples.size() == 0) begin
                    log_mismatch("no result expected", '0, got);
                end else begin
                    want = expected_samples.pop_front();
                    if (got !== want) begin
                        log_mismatch("result", want, got);
                    end
                end
            end
        end
    end

    // result side: random back-pressure plus one long hold-off
    initial begin
        int unsigned hold_left;
        bit          hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        m_ready   = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                m_ready   <= 1'b0;
            end else begin
                m_ready <= calm || ($urandom_range(99) >= 23);
            end
        end
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("FAIL pmt_pulse_shaper_discriminator");
        $finish;
    end

    task automatic apb_access(input logic wr, input logic [pmtps_pkg::ADDR_W-1:0] addr,
                              input logic [pmtps_pkg::DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (wr) begin
            if (addr == ADDR_THRESHOLD) begin
                thr_cfg = data[pmtps_pkg::SAMPLE_W-1:0];
            end
        end else if (prdata !== pmtps_pkg::DATA_W'(thr_cfg)) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("mismatch (threshold readback): expected %h, got %h",
                         pmtps_pkg::DATA_W'(thr_cfg), prdata);
            end
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    // register write only once the pipe has drained, then read the threshold back
    task automatic retune(input logic [pmtps_pkg::ADDR_W-1:0] addr,
                          input logic [pmtps_pkg::DATA_W-1:0] data);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_samples.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        apb_access(1'b1, addr, data);
        apb_access(1'b0, ADDR_THRESHOLD, '0);
    endtask

    task automatic send_tick(input logic [pmtps_pkg::AMP_W-1:0] amp, input logic typed,
                             input pmtps_pkg::disc_res_t res);
        if (!calm && $urandom_range(99) < 23) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_pe_amplitude <= amp;
        typed_valid    <= typed;
        typed_res      <= res;
        do @(posedge aclk); while (!s_ready);
    endtask

    initial begin
        logic [63:0]                    e;
        logic [63:0]                    num;
        int unsigned                    sent;
        int unsigned                    len;
        int unsigned                    mode;
        logic [pmtps_pkg::SAMPLE_W-1:0] thr;
        logic [pmtps_pkg::AMP_W-1:0]    amp;

        aresetn        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        s_valid        = 1'b0;
        s_pe_amplitude = '0;
        typed_valid    = 1'b0;
        typed_res      = '0;
        calm           = 1'b0;
        hold_req       = 1'b0;
        mismatches     = 0;

        e = UNIT_Q30;
        for (int k = 0; k < pmtps_pkg::TAPS; k++) begin
            num          = 64'(k) * e + SHAPE_RND;
            shape_tap[k] = num / SHAPE_DIV;
            e            = (e * DECAY_Q30 + (UNIT_Q30 >> 1)) >> 30;
        end
        for (int k = 0; k < pmtps_pkg::TAPS - 1; k++) begin
            amp_line[k] = '0;
        end
        disc_above = 1'b0;
        thr_cfg    = '0;

        // wr, addr, wdata, amplitude, typed, expected
        plan = '{
            // empty line after reset, h[0] = 0: sample equals threshold 0, no crossing
            '{1'b0, ADDR_THRESHOLD, 32'h0,        16'hFFFF, 1'b1, '{24'd0, 1'b0, 1'b0, 1'b0}},
            '{1'b0, ADDR_THRESHOLD, 32'h0,        16'h0000, 1'b0, '0},
            '{1'b0, ADDR_THRESHOLD, 32'h0,        16'hAAAA, 1'b0, '0},
            '{1'b0, ADDR_THRESHOLD, 32'h0,        16'h5555, 1'b0, '0},
            '{1'b0, ADDR_THRESHOLD, 32'h0,        16'h0001, 1'b0, '0},
            '{1'b0, ADDR_THRESHOLD, 32'h0,        16'h8000, 1'b0, '0},
            '{1'b0, ADDR_THRESHOLD, 32'h0,        16'h7FFF, 1'b0, '0},
            '{1'b0, ADDR_THRESHOLD, 32'h0,        16'hFFFF, 1'b0, '0},
            // upper bits dropped, threshold at full scale forces a fall
            '{1'b1, ADDR_THRESHOLD, 32'hFFFFFFFF, 16'h0000, 1'b0, '0},
            '{1'b0, ADDR_THRESHOLD, 32'h0,        16'hFFFF, 1'b0, '0},
            // write to an unmapped register must not touch the threshold
            '{1'b1, ADDR_UNUSED,    32'h0,        16'hFFFF, 1'b0, '0},
            '{1'b1, ADDR_THRESHOLD, 32'h00040000, 16'h0000, 1'b0, '0},
            '{1'b0, ADDR_THRESHOLD, 32'h0,        16'h0000, 1'b0, '0},
            '{1'b0, ADDR_THRESHOLD, 32'h0,        16'h0000, 1'b0, '0},
            '{1'b0, ADDR_THRESHOLD, 32'h0,        16'h0000, 1'b0, '0},
            '{1'b0, ADDR_THRESHOLD, 32'h0,        16'h0000, 1'b0, '0},
            '{1'b0, ADDR_THRESHOLD, 32'h0,        16'h0000, 1'b0, '0},
            '{1'b1, ADDR_THRESHOLD, 32'h0,        16'h0100, 1'b0, '0},
            '{1'b0, ADDR_THRESHOLD, 32'h0,        16'h0000, 1'b0, '0}
        };

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < PLAN_ROWS; i++) begin
            if (plan[i].wr) begin
                retune(plan[i].waddr, plan[i].wdata);
            end
            send_tick(plan[i].amp, plan[i].typed, plan[i].res);
        end

        // random phases, each with its own threshold suited to the pulse pattern
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            mode = $urandom_range(3);
            case (mode)
                MODE_SPARSE: begin
                    thr = ($urandom_range(3) == 0) ? '0 :
                          pmtps_pkg::SAMPLE_W'($urandom_range(3000));
                end
                MODE_DENSE: begin
                    thr = pmtps_pkg::SAMPLE_W'($urandom_range(450000, 200000));
                end
                MODE_BURST: begin
                    case ($urandom_range(2))
                        0:       thr = '0;
                        1:       thr = pmtps_pkg::SAMPLE_MAX;
                        default: thr = pmtps_pkg::SAMPLE_W'($urandom_range(24'h080000));
                    endcase
                end
                default: begin
                    thr = pmtps_pkg::SAMPLE_W'($urandom());
                end
            endcase
            if ($urandom_range(5) == 0) begin
                retune(ADDR_UNUSED, $urandom());
            end
            retune(ADDR_THRESHOLD, {8'($urandom_range(255)), thr});

            len = $urandom_range(110, 30);
            for (int i = 0; i < len; i++) begin
                case (mode)
                    MODE_SPARSE: begin
                        amp = ($urandom_range(99) < 8) ?
                              pmtps_pkg::AMP_W'($urandom_range(16'h0C00, 16'h0040)) : '0;
                    end
                    MODE_BURST: begin
                        amp = ($urandom_range(3) == 0) ? 16'hFFFF : 16'h0000;
                    end
                    default: begin
                        amp = pmtps_pkg::AMP_W'($urandom_range(16'hFFFF));
                    end
                endcase
                calm     = (sent >= CALM_FIRST) && (sent < CALM_LAST);
                hold_req = hold_req || (sent == HOLD_AT);
                send_tick(amp, 1'b0, '0);
                sent++;
            end
        end

        calm    = 1'b0;
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_samples.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("PASS pmt_pulse_shaper_discriminator");
        end else begin
            $display("FAIL pmt_pulse_shaper_discriminator");
        end
        $finish;
    end

endmodule

// ----- pmt_pulse_shaper_discriminator.f -----
rtl/pmtps_pkg.sv
rtl/pmtps_cell.sv
rtl/pmtps_chain.sv
rtl/pmtps_disc.sv
rtl/pmt_pulse_shaper_discriminator.sv
test/tb_pmt_pulse_shaper_discriminator.sv
